@@ rtl/haversine_distance_assert.svh @@
// Assertion macros for the haversine distance block.
// The files that assert include this header; the macros assume i_clk and i_rst_n.
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH
`ifndef SYNTH
`define HVD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("haversine_distance: assertion failed");
`define HVD_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("haversine_distance: implication failed");
`define HVD_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("haversine_distance: next-cycle check failed");
`else
`define HVD_ASSERT(lbl, prop)
`define HVD_IMPLY(lbl, cond, prop)
`define HVD_NEXT(lbl, cond, prop)
`endif
`endif

@@ rtl/hvd_pkg.sv @@
// Package for the haversine distance block: widths, fixed-point constants,
// the CORDIC arctangent table and the lane type. No dependencies.
`default_nettype none
package hvd_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam int ISQRT_STEPS  = 31;
    localparam int LAT_W        = 31;
    localparam int LON_W        = 32;
    localparam int ANG_W        = 32;
    localparam int CW           = 34;
    localparam int SQ_W         = 62;
    localparam int DIST_W       = 31;
    localparam int NLANES       = 4;

    localparam logic [30:0] KCONV        = 31'd1281023894;
    localparam logic [30:0] Q_ONE        = 31'd1073741824;
    localparam logic [31:0] CIRC_CM      = 32'd4003017359;
    localparam logic [30:0] HALF_CIRC_CM = 31'd2001508680;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    typedef logic signed [CW-1:0] t_cw;

    localparam t_cw CORDIC_X0 = 34'sd652032874;

    localparam t_cw ATAN_BAM [32] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81,
        34'sd41,        34'sd20,        34'sd10,        34'sd5,
        34'sd3,         34'sd1,         34'sd1,         34'sd0
    };

    typedef struct packed {
        logic                    flip;
        logic signed [ANG_W-1:0] z;
    } t_rot_in;
endpackage
`default_nettype wire

@@ rtl/haversine_distance.sv @@
// Top level of the haversine distance block: angle conversion, products,
// clamping and scaling around the CORDIC and square-root pipelines.
// Depends on hvd_pkg, hvd_sincos, hvd_isqrt, hvd_vec_cordic and the assertion header.
//
// Usage: a request on the input channel carries a start and an end coordinate
// pair in signed degrees times 1e7. It is taken at a clock edge where i_valid
// is high and o_stall is low. Each request yields exactly one result on the
// output channel, the great-circle distance in centimetres on o_distance_cm,
// taken where o_valid is high and i_stall is low.
// Throughput is one request per cycle while the receiver does not stall. The
// pipeline has three conversion stages, the sine/cosine CORDIC, three product
// and clamp stages, 31 square-root stages, the angle CORDIC and two scaling
// stages.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and o_stall is raised; nothing is lost or repeated.
// A synchronous reset clears all valid bits; the datapath needs no reset.
`default_nettype none
`include "haversine_distance_assert.svh"
module haversine_distance (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [hvd_pkg::LAT_W-1:0]  i_start_latitude,
    input  wire logic signed [hvd_pkg::LON_W-1:0]  i_start_longitude,
    input  wire logic signed [hvd_pkg::LAT_W-1:0]  i_end_latitude,
    input  wire logic signed [hvd_pkg::LON_W-1:0]  i_end_longitude,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [hvd_pkg::DIST_W-1:0]             o_distance_cm
);
    import hvd_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_ovld;

    logic signed [33:0] d_in [NLANES];
    logic [32:0]        r_m  [NLANES];
    logic [63:0]        r_p  [NLANES];
    t_rot_in            r_rot [NLANES];

    logic                    rot_vld;
    logic signed [ANG_W-1:0] rot_res [NLANES];

    logic signed [63:0] r_p1, r_p2, r_p3;
    logic signed [33:0] r_s1;
    logic signed [67:0] r_q;
    logic signed [39:0] a_sum;
    logic [30:0]        n_a, r_a;

    logic [30:0] sq_in [2];
    logic [30:0] sq_root [2];
    logic        sq_vld;

    logic        vec_vld;
    t_cw         vec_z;
    logic [30:0] z_clamp;
    logic [63:0] r_prod;
    logic [63:0] rounded;
    logic [31:0] d_raw;
    logic [DIST_W-1:0] r_out;

    assign en      = !(r_ovld && i_stall);
    assign o_stall = r_ovld && i_stall;
    assign o_valid = r_ovld;
    assign o_distance_cm = r_out;

    assign d_in[0] = 34'(i_end_latitude) - 34'(i_start_latitude);
    assign d_in[1] = 34'(i_end_longitude) - 34'(i_start_longitude);
    assign d_in[2] = 34'(i_start_latitude);
    assign d_in[3] = 34'(i_end_latitude);

    for (genvar l = 0; l < NLANES; l++) begin : g_conv
        localparam int SH = (l < 2) ? 31 : 30;
        localparam logic [63:0] RND = 64'(1) << (SH - 1);
        logic [31:0] t_raw, t_adj;
        always_comb begin
            t_raw = 32'((r_p[l] + RND) >> SH);
            t_adj = t_raw + QUARTER_TURN;
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m[l] <= d_in[l][33] ? 33'(-d_in[l]) : 33'(d_in[l]);
                r_p[l] <= 64'(r_m[l]) * 64'(KCONV);
                r_rot[l].flip <= t_adj[31];
                r_rot[l].z    <= t_adj[31] ? ANG_W'(t_raw - HALF_TURN) : ANG_W'(t_raw);
            end
        end
    end

    hvd_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_lane  (r_rot),
        .o_valid (rot_vld),
        .o_res   (rot_res)
    );

    always_comb begin
        a_sum = 40'(r_s1) + 40'(r_q >>> 30);
        if (a_sum[39]) begin
            n_a = '0;
        end else if (a_sum[38:0] > 39'(Q_ONE)) begin
            n_a = Q_ONE;
        end else begin
            n_a = a_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= rot_res[0] * rot_res[0];
            r_p2 <= rot_res[2] * rot_res[3];
            r_p3 <= rot_res[1] * rot_res[1];
            r_s1 <= 34'(r_p1 >>> 30);
            r_q  <= 68'(34'(r_p2 >>> 30)) * 68'(34'(r_p3 >>> 30));
            r_a  <= n_a;
        end
    end

    assign sq_in[0] = r_a;
    assign sq_in[1] = Q_ONE - r_a;

    hvd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v6),
        .i_a     (sq_in),
        .o_valid (sq_vld),
        .o_root  (sq_root)
    );

    hvd_vec_cordic u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_x     (sq_root[1]),
        .i_y     (sq_root[0]),
        .o_valid (vec_vld),
        .o_z     (vec_z)
    );

    always_comb begin
        if (vec_z[CW-1]) begin
            z_clamp = '0;
        end else if (vec_z[CW-2:0] > (CW-1)'(Q_ONE)) begin
            z_clamp = Q_ONE;
        end else begin
            z_clamp = vec_z[30:0];
        end
        rounded = r_prod + 64'(HALF_TURN);
        d_raw   = rounded[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 64'({z_clamp, 1'b0}) * 64'(CIRC_CM);
            r_out  <= (d_raw > 32'(HALF_CIRC_CM)) ? HALF_CIRC_CM : d_raw[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= rot_vld;
            r_v5   <= r_v4;
            r_v6   <= r_v5;
            r_v7   <= vec_vld;
            r_ovld <= r_v7;
        end
    end

    `HVD_IMPLY(a_dist_range, o_valid, o_distance_cm <= HALF_CIRC_CM)
    `HVD_IMPLY(a_a_range, r_v6, r_a <= Q_ONE)
    `HVD_NEXT(a_stall_freeze, o_stall, $stable(r_v1) && $stable(r_v7))
    `HVD_NEXT(a_no_phantom, !o_valid && !r_v7, !o_valid)
endmodule
`default_nettype wire

@@ rtl/hvd_sincos.sv @@
// Four-lane pipelined rotation CORDIC, one iteration per register stage.
// Lanes 0 and 1 return the sine, lanes 2 and 3 the cosine. Uses hvd_pkg.
`default_nettype none
module hvd_sincos (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire hvd_pkg::t_rot_in                  i_lane [hvd_pkg::NLANES],
    output logic                                   o_valid,
    output logic signed [hvd_pkg::ANG_W-1:0]       o_res  [hvd_pkg::NLANES]
);
    import hvd_pkg::*;

    t_cw  r_x    [CORDIC_STEPS][NLANES];
    t_cw  r_y    [CORDIC_STEPS][NLANES];
    t_cw  r_z    [CORDIC_STEPS][NLANES];
    logic r_flip [CORDIC_STEPS][NLANES];
    logic r_vld  [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        for (genvar l = 0; l < NLANES; l++) begin : g_lane
            t_cw  x_in, y_in, z_in, n_x, n_y, n_z;
            logic f_in;
            if (i == 0) begin : g_first
                assign x_in = CORDIC_X0;
                assign y_in = '0;
                assign z_in = CW'(i_lane[l].z);
                assign f_in = i_lane[l].flip;
            end else begin : g_next
                assign x_in = r_x[i-1][l];
                assign y_in = r_y[i-1][l];
                assign z_in = r_z[i-1][l];
                assign f_in = r_flip[i-1][l];
            end
            always_comb begin
                if (!z_in[CW-1]) begin
                    n_x = x_in - (y_in >>> i);
                    n_y = y_in + (x_in >>> i);
                    n_z = z_in - ATAN_BAM[i];
                end else begin
                    n_x = x_in + (y_in >>> i);
                    n_y = y_in - (x_in >>> i);
                    n_z = z_in + ATAN_BAM[i];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i][l]    <= n_x;
                    r_y[i][l]    <= n_y;
                    r_z[i][l]    <= n_z;
                    r_flip[i][l] <= f_in;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                if (i == 0) begin
                    r_vld[i] <= i_valid;
                end else begin
                    r_vld[i] <= r_vld[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    for (genvar l = 0; l < NLANES; l++) begin : g_out
        t_cw sel;
        if (l < 2) begin : g_sin
            assign sel = r_y[CORDIC_STEPS-1][l];
        end else begin : g_cos
            assign sel = r_x[CORDIC_STEPS-1][l];
        end
        assign o_res[l] = r_flip[CORDIC_STEPS-1][l] ? ANG_W'(-sel) : ANG_W'(sel);
    end

    assign o_valid = r_vld[CORDIC_STEPS-1];
endmodule
`default_nettype wire

@@ rtl/hvd_isqrt.sv @@
// Two-lane pipelined integer square root of a value in Q1.30 shifted up by 30,
// one result bit per register stage. Uses hvd_pkg.
`default_nettype none
module hvd_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [30:0]                 i_a    [2],
    output logic                             o_valid,
    output logic [30:0]                      o_root [2]
);
    import hvd_pkg::*;

    logic [SQ_W-1:0] r_v   [ISQRT_STEPS][2];
    logic [SQ_W-1:0] r_r   [ISQRT_STEPS][2];
    logic            r_vld [ISQRT_STEPS];

    for (genvar i = 0; i < ISQRT_STEPS; i++) begin : g_stage
        localparam logic [SQ_W-1:0] BITC = SQ_W'(1) << (2 * (ISQRT_STEPS - 1 - i));
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [SQ_W-1:0] v_in, r_in, trial, n_v, n_r;
            if (i == 0) begin : g_first
                assign v_in = SQ_W'({i_a[l], 30'b0});
                assign r_in = '0;
            end else begin : g_next
                assign v_in = r_v[i-1][l];
                assign r_in = r_r[i-1][l];
            end
            always_comb begin
                trial = r_in + BITC;
                if (v_in >= trial) begin
                    n_v = v_in - trial;
                    n_r = (r_in >> 1) + BITC;
                end else begin
                    n_v = v_in;
                    n_r = r_in >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[i][l] <= n_v;
                    r_r[i][l] <= n_r;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                if (i == 0) begin
                    r_vld[i] <= i_valid;
                end else begin
                    r_vld[i] <= r_vld[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign o_root[0] = r_r[ISQRT_STEPS-1][0][30:0];
    assign o_root[1] = r_r[ISQRT_STEPS-1][1][30:0];
    assign o_valid   = r_vld[ISQRT_STEPS-1];
endmodule
`default_nettype wire

@@ rtl/hvd_vec_cordic.sv @@
// Pipelined vectoring CORDIC giving the angle of (x, y) as a binary angle,
// one iteration per register stage. Uses hvd_pkg.
`default_nettype none
module hvd_vec_cordic (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [30:0]  i_x,
    input  wire logic [30:0]  i_y,
    output logic              o_valid,
    output hvd_pkg::t_cw      o_z
);
    import hvd_pkg::*;

    t_cw  r_x   [CORDIC_STEPS];
    t_cw  r_y   [CORDIC_STEPS];
    t_cw  r_z   [CORDIC_STEPS];
    logic r_vld [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        t_cw x_in, y_in, z_in, n_x, n_y, n_z;
        if (i == 0) begin : g_first
            assign x_in = CW'(i_x);
            assign y_in = CW'(i_y);
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end
        always_comb begin
            if (!y_in[CW-1]) begin
                n_x = x_in + (y_in >>> i);
                n_y = y_in - (x_in >>> i);
                n_z = z_in + ATAN_BAM[i];
            end else begin
                n_x = x_in - (y_in >>> i);
                n_y = y_in + (x_in >>> i);
                n_z = z_in - ATAN_BAM[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                if (i == 0) begin
                    r_vld[i] <= i_valid;
                end else begin
                    r_vld[i] <= r_vld[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign o_z     = r_z[CORDIC_STEPS-1];
    assign o_valid = r_vld[CORDIC_STEPS-1];
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for haversine_distance: random and directed coordinate requests,
// with a scoreboard class that predicts each distance in fixed point.
// Depends on hvd_pkg and the haversine_distance RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = hvd_pkg::CORDIC_STEPS;
    localparam int LATENCY = 2 * STEPS + 39;
    localparam longint MAX_CYCLES = 400000;

    class distance_board;
        logic [30:0] pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function longint fl(longint v, int s);
            return v >>> s;
        endfunction

        static function void rot(logic [31:0] t, output longint s, output longint c);
            longint x, y, z, dx, dy;
            bit flip;
            x = 652032874;
            y = 0;
            flip = 0;
            if (((t + 32'h4000_0000) & 32'h8000_0000) != 0) begin
                t = t - 32'h8000_0000;
                flip = 1;
            end
            z = longint'($signed(t));
            for (int i = 0; i < STEPS; i++) begin
                dx = fl(y, i % 32);
                dy = fl(x, i % 32);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= hvd_pkg::ATAN_BAM[i % 32];
                end else begin
                    x += dx; y -= dy; z += hvd_pkg::ATAN_BAM[i % 32];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        static function logic [31:0] to_angle(longint d, int sh);
            logic [63:0] m, p;
            m = (d < 0) ? -d : d;
            p = m * 64'd1281023894 + (64'd1 << (sh - 1));
            return p[31 + sh -: 32];
        endfunction

        static function longint root(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        static function logic [30:0] distance(longint la1, longint lo1,
                                              longint la2, longint lo2);
            longint s1, s2, c1, c2, dm, a, x, y, z, dx, dy;
            logic [63:0] d;
            rot(to_angle(la2 - la1, 31), s1, dm);
            rot(to_angle(lo2 - lo1, 31), s2, dm);
            rot(to_angle(la1, 30), dm, c1);
            rot(to_angle(la2, 30), dm, c2);
            a = fl(s1 * s1, 30) + fl(fl(c1 * c2, 30) * fl(s2 * s2, 30), 30);
            if (a < 0) a = 0;
            if (a > 1073741824) a = 1073741824;
            y = root(a << 30);
            x = root((1073741824 - a) << 30);
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = fl(y, i % 32);
                dy = fl(x, i % 32);
                if (y >= 0) begin
                    x += dx; y -= dy; z += hvd_pkg::ATAN_BAM[i % 32];
                end else begin
                    x -= dx; y += dy; z -= hvd_pkg::ATAN_BAM[i % 32];
                end
            end
            if (z < 0) z = 0;
            if (z > 1073741824) z = 1073741824;
            d = (64'(2 * z) * 64'd4003017359 + 64'h8000_0000) >> 32;
            if (d > 64'd2001508680) d = 64'd2001508680;
            return d[30:0];
        endfunction

        function void note_request(longint la1, longint lo1, longint la2, longint lo2);
            pending.push_back(distance(la1, lo1, la2, lo2));
        endfunction

        function void check_distance(logic [30:0] got);
            logic [30:0] want;
            if (pending.size() == 0) begin
                $error("unexpected result distance_cm=%0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $error("distance_cm expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic signed [30:0] i_start_latitude = 0;
    logic signed [31:0] i_start_longitude = 0;
    logic signed [30:0] i_end_latitude = 0;
    logic signed [31:0] i_end_longitude = 0;
    logic o_stall, o_valid;
    logic [30:0] o_distance_cm;

    distance_board board = new();
    longint cycles = 0;
    bit calm = 0;

    haversine_distance dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("haversine_distance test failed");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) board.check_distance(o_distance_cm);
        if (i_rst_n && i_valid && !o_stall)
            board.note_request(i_start_latitude, i_start_longitude,
                               i_end_latitude, i_end_longitude);
    end

    always @(negedge i_clk) i_stall <= !calm && ($urandom_range(99) < 8);

    task automatic send_request(longint la1, longint lo1, longint la2, longint lo2);
        while (!calm && $urandom_range(99) < 8) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_start_latitude <= la1[30:0];
        i_start_longitude <= lo1[31:0];
        i_end_latitude <= la2[30:0];
        i_end_longitude <= lo2[31:0];
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic longint rnd_lat(bit wide);
        if (wide) return longint'($signed(31'($urandom)));
        return longint'($urandom_range(1800000000)) - 900000000;
    endfunction

    function automatic longint rnd_lon(bit wide);
        if (wide) return longint'($signed($urandom));
        return longint'($urandom_range(3600000000)) - 1800000000;
    endfunction

    initial begin
        longint la, lo;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_request(0, 0, 0, 0);
        send_request(900000000, 0, -900000000, 0);
        send_request(-900000000, 0, 900000000, 0);
        send_request(0, 1800000000, 0, -1800000000);
        send_request(0, 0, 0, 1800000000);
        send_request(0, -1800000000, 0, 1800000000);
        send_request(0, 0, 0, 1799999999);
        send_request(900000000, 1234, 900000000, -99999);
        send_request(-1073741824, -2147483648, 1073741823, 2147483647);
        send_request(1073741823, 2147483647, -1073741824, -2147483648);
        send_request(1073741823, 0, 1073741823, 0);
        send_request(450000000, 100000000, 450000001, 100000001);
        send_request(0, 0, 1, 1);
        send_request(-1, -1, 0, 0);
        send_request(515000000, -1200000, 407000000, -740000000);
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        for (int n = 0; n < 600; n++) begin
            calm = (n >= 200 && n < 300);
            la = rnd_lat(n % 7 == 0);
            lo = rnd_lon(n % 5 == 0);
            if (n % 4 == 1)
                send_request(la, lo, la + $urandom_range(2000) - 1000,
                             lo + $urandom_range(2000) - 1000);
            else if (n % 9 == 2)
                send_request(la, lo, -la, lo + 1800000000);
            else
                send_request(la, lo, rnd_lat(n % 11 == 0), rnd_lon(n % 3 == 0));
            if (n == 400) begin
                i_valid <= 0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end
        end
        calm = 0;
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("haversine_distance test passed");
        else
            $display("haversine_distance test failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ haversine_distance.f @@
+incdir+rtl
rtl/hvd_pkg.sv
rtl/hvd_sincos.sv
rtl/hvd_isqrt.sv
rtl/hvd_vec_cordic.sv
rtl/haversine_distance.sv
dv/tb_top.sv
